// ===== rtl/core/grid_ray_marcher_assert.svh =====
// grid_ray_marcher_assert.svh: concurrent assertion macros for the ray marcher.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef GRID_RAY_MARCHER_ASSERT_SVH
`define GRID_RAY_MARCHER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define GRM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define GRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/grm_pkg.sv =====
// grm_pkg.sv: shared widths, constants, sine table builder and step verdict type
// for the grid ray marcher. No dependencies.
package grm_pkg;

  // Field and datapath widths
  localparam int unsigned COLUMN_W    = 10;
  localparam int unsigned ANGLE_W     = 24;
  localparam int unsigned PLAYER_W    = 26;
  localparam int unsigned POS_W       = 28;  // signed Q11.16 march position
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned HIT_W       = 27;
  localparam int unsigned STEPS_OUT_W = 11;
  localparam int unsigned SINE_W      = 17;  // table magnitude, 0..65536
  localparam int unsigned SIN_W       = 18;  // signed unit step
  localparam int unsigned ROM_DEPTH   = 1025;
  localparam int unsigned ROM_AW      = 11;
  localparam int unsigned MAP_ROW_W   = 50;  // five rows per map register
  localparam int unsigned ROW_STRIDE  = 10;  // bits per map row
  localparam int unsigned MAP_DIM     = 10;  // rows held in the two registers
  localparam int unsigned TILE_IDX_W  = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 50;

  // Angle constants, 2^-24 turn units
  localparam int unsigned FOV_UNITS    = 2796203;
  localparam int unsigned HALF_FOV     = FOV_UNITS / 2;
  localparam int unsigned QUARTER_TURN = 32'h0040_0000;
  localparam int unsigned TABLE_LAST   = 1024;
  localparam int unsigned IDX_ROUND    = 2048;

  // Taylor series constant, pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Register reset values
  localparam logic [PLAYER_W-1:0]  PLAYER_RST   = 26'd19660800;
  localparam logic [ANGLE_W-1:0]   VIEW_RST     = 24'd0;
  localparam logic [MAP_ROW_W-1:0] MAP_LOW_RST  = 50'd635059859621887;
  localparam logic [MAP_ROW_W-1:0] MAP_HIGH_RST = 50'd1125351897572873;

  // Outcome of testing one march position
  typedef struct packed {
    logic outside;  // tile off the map
    logic wall;     // tile on the map and a wall
  } march_verdict_t;

  // Taylor term divisor (2n)(2n+1)
  function automatic logic [63:0] taylor_div(input logic [63:0] term, input int unsigned n);
    logic [63:0] res;
    unique case (n)
      1:       res = term / 64'd6;
      2:       res = term / 64'd20;
      3:       res = term / 64'd42;
      4:       res = term / 64'd72;
      5:       res = term / 64'd110;
      6:       res = term / 64'd156;
      default: res = term / 64'd210;
    endcase
    return res;
  endfunction

  // Table entry k = round(2^16 * sin(k * pi / 2048)), integer Taylor series in Q30
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30) >> 10;
    term = x;
    sum  = signed'(x);
    for (int unsigned n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = taylor_div(term, n);
      if ((n & 1) != 0) sum = sum - signed'(term);
      else              sum = sum + signed'(term);
    end
    if (sum < 0) sum = 64'sd0;
    r = (unsigned'(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[SINE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/grid_ray_marcher.sv =====
// grid_ray_marcher: casts one ray per screen column through a tile map.
// Sequencer: angle, cosine lookup, sine lookup, first step, march (n steps in all,
// 1..MAX_STEPS), done; a new request is taken only once it is back in idle.
// One step per cycle through the shared step adder and tile tester.
// Reset: configuration registers return to their defaults, no ray in flight.
`include "grid_ray_marcher_assert.svh"

module grid_ray_marcher #(
  parameter int unsigned MAP_COLS    = 10,
  parameter int unsigned MAP_ROWS    = 10,
  parameter int unsigned TILE_PIXELS = 64,
  parameter int unsigned RAY_COUNT   = 800,
  parameter int unsigned MAX_STEPS   = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [grm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [grm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [grm_pkg::COLUMN_W-1:0]        column_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [grm_pkg::COLUMN_W-1:0]        column_out_o,
  output logic signed [grm_pkg::HIT_W-1:0]    hit_x_o,
  output logic signed [grm_pkg::HIT_W-1:0]    hit_y_o,
  output logic                                wall_hit_o,
  output logic [grm_pkg::STEPS_OUT_W-1:0]     steps_taken_o
);
  import grm_pkg::*;

  localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);
  localparam logic [ANGLE_W-1:0] RAY_STEP = ANGLE_W'(FOV_UNITS / RAY_COUNT);

  typedef enum logic [2:0] {
    CFG_PLAYER_X  = 3'd0,
    CFG_PLAYER_Y  = 3'd1,
    CFG_VIEW      = 3'd2,
    CFG_MAP_LOW   = 3'd3,
    CFG_MAP_HIGH  = 3'd4
  } cfg_reg_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ANGLE = 7'b0000010,
    S_COS   = 7'b0000100,
    S_SIN   = 7'b0001000,
    S_START = 7'b0010000,
    S_MARCH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  // configuration
  logic [PLAYER_W-1:0]  player_x_q, player_y_q;
  logic [ANGLE_W-1:0]   view_q;
  logic [MAP_ROW_W-1:0] map_low_q, map_high_q;

  // sequencer and ray datapath
  state_e                   state_q, state_d;
  logic [COLUMN_W-1:0]      column_q;
  logic [ANGLE_W-1:0]       angle_q, angle_d, angle_mul, lookup_angle;
  logic [ROM_AW-1:0]        rom_addr;
  logic [SINE_W-1:0]        rom_data;
  logic                     lookup_neg, rom_neg_q;
  logic signed [SIN_W-1:0]  sine_mag, sine_val;
  logic signed [SIN_W-1:0]  dx_q, dy_q, delta_y;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q, base_x, base_y, sum_x, sum_y;
  logic [STEP_W-1:0]        steps_q;
  logic                     hit_q;
  logic                     at_limit, march_end;
  logic [STEP_W+STEPS_OUT_W-1:0] steps_ext;
  march_verdict_t           verdict;

  // output register
  logic                     out_valid_q, out_load;
  logic [COLUMN_W-1:0]      column_out_q;
  logic signed [HIT_W-1:0]  hit_x_q, hit_y_q;
  logic                     wall_hit_q;
  logic [STEPS_OUT_W-1:0]   steps_out_q;

  // Table index of an angle: quadrant folds, rounded to the nearest entry
  function automatic logic [ROM_AW:0] sine_lookup(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-2:0] rnd;
    logic [ROM_AW-1:0]  idx;
    rnd = {1'b0, a[ANGLE_W-3:0]} + (ANGLE_W-1)'(IDX_ROUND);
    idx = rnd[ANGLE_W-2:12];
    if (a[ANGLE_W-2]) idx = ROM_AW'(TABLE_LAST) - idx;
    return {a[ANGLE_W-1], idx};
  endfunction

  // Configuration writes, taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= PLAYER_RST;
      player_y_q <= PLAYER_RST;
      view_q     <= VIEW_RST;
      map_low_q  <= MAP_LOW_RST;
      map_high_q <= MAP_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PLAYER_X: player_x_q <= cfg_data_i[PLAYER_W-1:0];
        CFG_PLAYER_Y: player_y_q <= cfg_data_i[PLAYER_W-1:0];
        CFG_VIEW:     view_q     <= cfg_data_i[ANGLE_W-1:0];
        CFG_MAP_LOW:  map_low_q  <= cfg_data_i[MAP_ROW_W-1:0];
        CFG_MAP_HIGH: map_high_q <= cfg_data_i[MAP_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Ray angle: view - half field + column * per-ray step, wraps
  assign angle_mul = ANGLE_W'(column_q) * RAY_STEP;
  assign angle_d   = view_q - ANGLE_W'(HALF_FOV) + angle_mul;

  // Sine table port: cosine first, then sine
  assign lookup_angle = (state_q == S_COS) ? angle_q + ANGLE_W'(QUARTER_TURN) : angle_q;
  assign {lookup_neg, rom_addr} = sine_lookup(lookup_angle);

  grm_sine_rom u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign sine_mag = signed'(SIN_W'(rom_data));
  assign sine_val = rom_neg_q ? -sine_mag : sine_mag;

  // Step unit operands: first step from the player, then from the last position
  assign base_x  = (state_q == S_START) ? signed'(POS_W'(player_x_q)) : pos_x_q;
  assign base_y  = (state_q == S_START) ? signed'(POS_W'(player_y_q)) : pos_y_q;
  assign delta_y = (state_q == S_START) ? sine_val : dy_q;

  grm_march_unit #(
    .MAP_COLS    (MAP_COLS),
    .MAP_ROWS    (MAP_ROWS),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_march_unit (
    .base_x_i  (base_x),
    .base_y_i  (base_y),
    .delta_x_i (dx_q),
    .delta_y_i (delta_y),
    .eval_x_i  (pos_x_q),
    .eval_y_i  (pos_y_q),
    .map_i     ({map_high_q, map_low_q}),
    .sum_x_o   (sum_x),
    .sum_y_o   (sum_y),
    .verdict_o (verdict)
  );

  assign at_limit  = (steps_q == STEP_W'(MAX_STEPS));
  assign march_end = verdict.outside || verdict.wall || at_limit;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ANGLE;
      S_ANGLE: state_d = S_COS;
      S_COS:   state_d = S_SIN;
      S_SIN:   state_d = S_START;
      S_START: state_d = S_MARCH;
      S_MARCH: if (march_end) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Ray datapath registers
  always_ff @(posedge clk_i) begin
    rom_neg_q <= lookup_neg;
    if (in_valid_i && !in_stall_o) column_q <= column_i;
    if (state_q == S_ANGLE) angle_q <= angle_d;
    if (state_q == S_SIN) dx_q <= sine_val;
    if (state_q == S_START) begin
      dy_q    <= sine_val;
      pos_x_q <= sum_x;
      pos_y_q <= sum_y;
      steps_q <= STEP_W'(1);
    end
    if (state_q == S_MARCH) begin
      if (march_end) begin
        hit_q <= verdict.wall;
      end else begin
        pos_x_q <= sum_x;
        pos_y_q <= sum_y;
        steps_q <= steps_q + STEP_W'(1);
      end
    end
  end

  // Result register, frees the sequencer while a result waits
  assign steps_ext = {STEPS_OUT_W'(0), steps_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      column_out_q <= column_q;
      hit_x_q      <= pos_x_q[HIT_W-1:0];
      hit_y_q      <= pos_y_q[HIT_W-1:0];
      wall_hit_q   <= hit_q;
      steps_out_q  <= steps_ext[STEPS_OUT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign column_out_o  = column_out_q;
  assign hit_x_o       = hit_x_q;
  assign hit_y_o       = hit_y_q;
  assign wall_hit_o    = wall_hit_q;
  assign steps_taken_o = steps_out_q;

  // Checks
  `GRM_ASSERT_NEXT(a_accept_starts_ray, in_valid_i && !in_stall_o, state_q == S_ANGLE, "accepted request did not start a ray")
  `GRM_ASSERT_SAME(a_steps_in_range, state_q == S_MARCH, steps_q != '0 && steps_q <= STEP_W'(MAX_STEPS), "step count out of range while marching")
  `GRM_ASSERT_SAME(a_result_from_done, $rose(out_valid_o), $past(state_q == S_DONE), "result valid rose without a finished ray")

endmodule

// ===== rtl/core/grm_sine_rom.sv =====
// grm_sine_rom.sv: quarter-wave sine table, Q1.16 magnitudes, registered read.
// Depends on grm_pkg (table builder and widths).
module grm_sine_rom (
  input  logic                        clk_i,
  input  logic [grm_pkg::ROM_AW-1:0]  addr_i,
  output logic [grm_pkg::SINE_W-1:0]  data_o
);
  import grm_pkg::*;

  logic [SINE_W-1:0] rom_w [ROM_DEPTH];
  logic [SINE_W-1:0] data_q;

  // Table contents fixed at elaboration
  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_entry
    localparam logic [SINE_W-1:0] ENTRY = sine_entry(k);
    assign rom_w[k] = ENTRY;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/grm_march_unit.sv =====
// grm_march_unit.sv: shared step unit, adds the unit step to a position and
// tests a position against the tile map. Depends on grm_pkg.
module grm_march_unit #(
  parameter int unsigned MAP_COLS    = 10,
  parameter int unsigned MAP_ROWS    = 10,
  parameter int unsigned TILE_PIXELS = 64
) (
  input  logic signed [grm_pkg::POS_W-1:0]       base_x_i,
  input  logic signed [grm_pkg::POS_W-1:0]       base_y_i,
  input  logic signed [grm_pkg::SIN_W-1:0]       delta_x_i,
  input  logic signed [grm_pkg::SIN_W-1:0]       delta_y_i,
  input  logic signed [grm_pkg::POS_W-1:0]       eval_x_i,
  input  logic signed [grm_pkg::POS_W-1:0]       eval_y_i,
  input  logic [2*grm_pkg::MAP_ROW_W-1:0]        map_i,
  output logic signed [grm_pkg::POS_W-1:0]       sum_x_o,
  output logic signed [grm_pkg::POS_W-1:0]       sum_y_o,
  output grm_pkg::march_verdict_t                verdict_o
);
  import grm_pkg::*;

  // Pixel integer part and exact reciprocal for the divide by tile size
  localparam int unsigned IP_W     = POS_W - FRAC_W;
  localparam int unsigned TILE_SH  = $clog2(TILE_PIXELS);
  localparam int unsigned RECIP_SH = IP_W + TILE_SH;
  localparam int unsigned PROD_W   = IP_W + RECIP_SH;
  localparam int unsigned RECIP    = ((1 << RECIP_SH) + TILE_PIXELS - 1) / TILE_PIXELS;

  logic [ROW_STRIDE-1:0]  rows [MAP_DIM];
  logic [TILE_IDX_W:0]    tile_x;
  logic [TILE_IDX_W:0]    tile_y;
  logic                   off_map;

  // Tile of one axis, integer part truncated toward zero; top bit flags off map
  function automatic logic [TILE_IDX_W:0] axis_tile(input logic signed [POS_W-1:0] pos,
                                                    input int unsigned limit);
    logic [POS_W-1:0]  mag;
    logic [IP_W-1:0]   ip;
    logic [PROD_W-1:0] prod;
    logic [IP_W-1:0]   quo;
    logic              outside;
    mag  = pos[POS_W-1] ? POS_W'(-pos) : POS_W'(pos);
    ip   = mag[POS_W-1:FRAC_W];
    prod = PROD_W'(ip) * PROD_W'(RECIP);
    quo  = prod[PROD_W-1:RECIP_SH];
    if (pos[POS_W-1]) begin
      // negative side: tile 0 until a whole tile is passed
      outside = (ip >= IP_W'(TILE_PIXELS));
      quo     = '0;
    end else begin
      outside = (quo >= IP_W'(limit));
    end
    return {outside, quo[TILE_IDX_W-1:0]};
  endfunction

  // Step adders
  assign sum_x_o = base_x_i + POS_W'(delta_x_i);
  assign sum_y_o = base_y_i + POS_W'(delta_y_i);

  // Map rows, fixed stride of ten bits
  always_comb begin
    for (int r = 0; r < MAP_DIM; r++) begin
      rows[r] = map_i[r*ROW_STRIDE +: ROW_STRIDE];
    end
  end

  // Tile test
  assign tile_x  = axis_tile(eval_x_i, MAP_COLS);
  assign tile_y  = axis_tile(eval_y_i, MAP_ROWS);
  assign off_map = tile_x[TILE_IDX_W] | tile_y[TILE_IDX_W];

  assign verdict_o.outside = off_map;
  assign verdict_o.wall    = !off_map &&
                             rows[tile_y[TILE_IDX_W-1:0]][tile_x[TILE_IDX_W-1:0]];

endmodule

// ===== sim/grid_ray_marcher_tb.sv =====
// grid_ray_marcher_tb.sv: self-checking testbench for the grid ray marcher.
// Needs grm_pkg and the grid_ray_marcher RTL. A local ray tracer predicts every
// result; random idling, stalls and map settings exercise the handshakes.
`timescale 1ns / 100ps

module grid_ray_marcher_tb;

  import grm_pkg::*;

  localparam int MAP_COLS    = 10;
  localparam int MAP_ROWS    = 10;
  localparam int TILE_PIXELS = 64;
  localparam int RAY_COUNT   = 800;
  localparam int MAX_STEPS   = 1024;

  localparam int unsigned RAY_STEP     = FOV_UNITS / RAY_COUNT;
  localparam int unsigned PLAYER_MAX   = 41943039;
  localparam int unsigned RANDOM_RAYS  = 560;
  localparam int unsigned HOLD_CYCLES  = 2000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned CLK_HALF     = 5;

  typedef longint unsigned u64_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAYER_X,
    REG_PLAYER_Y,
    REG_VIEW_ANGLE,
    REG_MAP_LOW,
    REG_MAP_HIGH
  } cfg_reg_e;

  typedef struct packed {
    logic [COLUMN_W-1:0]        column;
    logic signed [HIT_W-1:0]    hit_x;
    logic signed [HIT_W-1:0]    hit_y;
    logic                       wall;
    logic [STEPS_OUT_W-1:0]     steps;
  } ray_result_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Block ports; the driven inputs are known from time zero
  logic                   cfg_valid_r = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_r = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_r  = '0;
  logic                   cfg_ready_o;
  logic                   in_valid_r  = 1'b0;
  logic                   in_stall_o;
  logic [COLUMN_W-1:0]    column_r    = '0;
  logic                   out_valid_o;
  logic                   out_stall_r = 1'b0;
  logic [COLUMN_W-1:0]    column_out_o;
  logic signed [HIT_W-1:0] hit_x_o;
  logic signed [HIT_W-1:0] hit_y_o;
  logic                   wall_hit_o;
  logic [STEPS_OUT_W-1:0] steps_taken_o;

  // Shadow of the configuration registers
  logic [PLAYER_W-1:0] cur_px   = PLAYER_RST;
  logic [PLAYER_W-1:0] cur_py   = PLAYER_RST;
  logic [ANGLE_W-1:0]  cur_view = VIEW_RST;
  logic [99:0]         cur_map  = {MAP_HIGH_RST, MAP_LOW_RST};

  longint signed  sine_lut [0:TABLE_LAST];
  logic [COLUMN_W-1:0] column_q [$];
  ray_result_t    ray_expect_q [$];
  int unsigned    gap_left    = 0;
  int unsigned    stall_left  = 0;
  int unsigned    hold_left   = 0;
  int unsigned    held_results = 0;
  int unsigned    mismatches  = 0;
  bit             quiet_mode  = 1'b0;

  grid_ray_marcher #(
    .MAP_COLS   (MAP_COLS),
    .MAP_ROWS   (MAP_ROWS),
    .TILE_PIXELS(TILE_PIXELS),
    .RAY_COUNT  (RAY_COUNT),
    .MAX_STEPS  (MAX_STEPS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_r),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_r),
    .cfg_data_i   (cfg_data_r),
    .in_valid_i   (in_valid_r),
    .in_stall_o   (in_stall_o),
    .column_i     (column_r),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_r),
    .column_out_o (column_out_o),
    .hit_x_o      (hit_x_o),
    .hit_y_o      (hit_y_o),
    .wall_hit_o   (wall_hit_o),
    .steps_taken_o(steps_taken_o)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Quarter-wave sine entry, Q16, from a Q30 Taylor series
  function automatic longint signed taylor_sine(input int unsigned k);
    u64_t          x;
    u64_t          term;
    u64_t          r;
    longint signed acc;
    x    = (u64_t'(k) * HALF_PI_Q30) >> 10;
    term = x;
    acc  = signed'(x);
    for (int unsigned n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / u64_t'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - signed'(term);
      else            acc = acc + signed'(term);
    end
    if (acc < 0) acc = 0;
    r = (u64_t'(acc) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return signed'(r);
  endfunction

  initial begin
    for (int unsigned k = 0; k <= TABLE_LAST; k++) sine_lut[k] = taylor_sine(k);
  end

  // Signed Q1.16 sine of a 24-bit turn angle, nearest table entry
  function automatic longint signed unit_sine(input logic [ANGLE_W-1:0] a);
    int unsigned idx;
    idx = (32'(a[21:0]) + IDX_ROUND) >> 12;
    if (a[22]) idx = TABLE_LAST - idx;
    return a[23] ? -sine_lut[idx] : sine_lut[idx];
  endfunction

  // Tile index: pixel truncated toward zero, then divided toward zero
  function automatic longint signed tile_index(input longint signed pos);
    longint signed pix;
    pix = (pos < 0) ? -((-pos) >> FRAC_W) : (pos >> FRAC_W);
    return pix / longint'(TILE_PIXELS);
  endfunction

  // March one column's ray over the shadow map
  function automatic ray_result_t trace_ray(input logic [COLUMN_W-1:0] col);
    ray_result_t   res;
    logic [ANGLE_W-1:0] ang;
    longint signed dx, dy, px, py, tx, ty;
    int            steps;
    bit            wall;
    bit            done;
    ang   = ANGLE_W'(32'(cur_view) - HALF_FOV + 32'(col) * RAY_STEP);
    dx    = unit_sine(ang + ANGLE_W'(QUARTER_TURN));
    dy    = unit_sine(ang);
    px    = longint'(cur_px);
    py    = longint'(cur_py);
    steps = 0;
    wall  = 1'b0;
    done  = 1'b0;
    while (!done && steps < MAX_STEPS) begin
      px = px + dx;
      py = py + dy;
      steps++;
      tx = tile_index(px);
      ty = tile_index(py);
      if (tx < 0 || tx >= MAP_COLS || ty < 0 || ty >= MAP_ROWS) begin
        done = 1'b1;
      end else if (cur_map[int'(ty) * ROW_STRIDE + int'(tx)]) begin
        wall = 1'b1;
        done = 1'b1;
      end
    end
    res.column = col;
    res.hit_x  = px[HIT_W-1:0];
    res.hit_y  = py[HIT_W-1:0];
    res.wall   = wall;
    res.steps  = STEPS_OUT_W'(steps);
    return res;
  endfunction

  // Mostly short idle stretches, a few long ones
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Request driver: holds a stalled request, then idles a random gap (none in quiet mode)
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    int unsigned gap;
    if (!rst_ni) begin
      in_valid_r <= 1'b0;
      column_r   <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_r && !in_stall_o) begin
        ray_expect_q.push_back(trace_ray(column_r));
        gap = quiet_mode ? 0 : idle_length();
      end else begin
        gap = gap_left;
      end
      if (in_valid_r && in_stall_o) begin
        // payload held while stalled
      end else if (gap != 0) begin
        in_valid_r <= 1'b0;
        gap_left   <= gap - 1;
      end else if (column_q.size() != 0) begin
        in_valid_r <= 1'b1;
        column_r   <= column_q.pop_front();
        gap_left   <= 0;
      end else begin
        in_valid_r <= 1'b0;
        gap_left   <= 0;
      end
    end
  end

  // Long hold-off on the result side every so often, so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      held_results <= 0;
    end else if (out_valid_o && !out_stall_r) begin
      held_results <= held_results + 1;
      if (held_results % 150 == 40 && column_q.size() > 1) hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result-side stall
  always @(posedge clk_i or negedge rst_ni) begin : drive_stall
    int unsigned len;
    if (!rst_ni) begin
      out_stall_r <= 1'b0;
      stall_left  <= 0;
    end else if (hold_left != 0) begin
      out_stall_r <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall_r <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      len = quiet_mode ? 0 : idle_length();
      out_stall_r <= (len != 0);
      stall_left  <= (len != 0) ? len - 1 : 0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    ray_result_t got;
    ray_result_t want;
    if (rst_ni && out_valid_o && !out_stall_r) begin
      got = '{column_out_o, hit_x_o, hit_y_o, wall_hit_o, steps_taken_o};
      if (ray_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result for column %0d with no request outstanding", $time,
                   got.column);
      end else begin
        want = ray_expect_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: want column %0d x %0d y %0d wall %0b steps %0d", $time,
                     want.column, want.hit_x, want.hit_y, want.wall, want.steps);
            $display("%0t: got  column %0d x %0d y %0d wall %0b steps %0d", $time,
                     got.column, got.hit_x, got.hit_y, got.wall, got.steps);
          end
        end
      end
    end
  end

  // One register write; valid stays up for a following write
  task automatic write_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] d);
    cfg_valid_r <= 1'b1;
    cfg_index_r <= r;
    cfg_data_r  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      REG_PLAYER_X:   cur_px = d[PLAYER_W-1:0];
      REG_PLAYER_Y:   cur_py = d[PLAYER_W-1:0];
      REG_VIEW_ANGLE: cur_view = d[ANGLE_W-1:0];
      REG_MAP_LOW:    cur_map[49:0] = d;
      REG_MAP_HIGH:   cur_map[99:50] = d;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [PLAYER_W-1:0] px, input logic [PLAYER_W-1:0] py,
                             input logic [ANGLE_W-1:0] view, input logic [99:0] map);
    write_reg(REG_PLAYER_X, CFG_DATA_W'(px));
    write_reg(REG_PLAYER_Y, CFG_DATA_W'(py));
    write_reg(REG_VIEW_ANGLE, CFG_DATA_W'(view));
    write_reg(REG_MAP_LOW, map[49:0]);
    write_reg(REG_MAP_HIGH, map[99:50]);
    cfg_valid_r <= 1'b0;
  endtask

  // Wait until every request went out and every result came back
  task automatic wait_idle();
    while (column_q.size() != 0 || in_valid_r || ray_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_columns(input int unsigned cols[$]);
    foreach (cols[i]) column_q.push_back(COLUMN_W'(cols[i]));
    wait_idle();
  endtask

  function automatic logic [PLAYER_W-1:0] random_player();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return PLAYER_MAX;
    return $urandom_range(0, PLAYER_MAX);
  endfunction

  // Mostly walled rooms with sparse interior walls; some odd maps
  function automatic logic [99:0] random_map();
    logic [99:0] m;
    int unsigned mode;
    int unsigned density;
    mode    = $urandom_range(0, 9);
    density = (mode <= 5) ? $urandom_range(5, 30) : 10;
    for (int y = 0; y < MAP_ROWS; y++)
      for (int x = 0; x < MAP_COLS; x++)
        m[y * ROW_STRIDE + x] = (mode <= 5 && (x == 0 || y == 0 || x == MAP_COLS - 1 ||
                                 y == MAP_ROWS - 1)) || ($urandom_range(0, 99) < density);
    if (mode == 7) m = {$urandom(), $urandom(), $urandom(), $urandom()};
    if (mode == 8) m = '0;
    if (mode == 9) m = '1;
    return m;
  endfunction

  function automatic logic [COLUMN_W-1:0] random_column();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, RAY_COUNT - 1);
  endfunction

  // Stimulus: directed rays, then random phases with fresh settings
  initial begin
    int unsigned sent;
    int unsigned n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default settings, including columns past the screen edge
    run_columns('{0, 799, 400, 800, 1023});
    // empty map: rays leave the map
    load_config(PLAYER_RST, PLAYER_RST, '0, '0);
    run_columns('{0, 399, 799});
    // corner start facing away: the ray runs through negative positions
    load_config('0, '0, 24'h800000, '0);
    run_columns('{400, 0, 799});
    load_config(PLAYER_MAX, PLAYER_MAX, 24'h200000, '0);
    run_columns('{400, 0});
    // start inside a wall: every tile a wall
    load_config(PLAYER_MAX, PLAYER_MAX, 24'hFFFFFF, '1);
    run_columns('{400, 1023});
    // only the start tile walled
    load_config(PLAYER_RST, PLAYER_RST, 24'h400000, 100'(1) << (4 * ROW_STRIDE + 4));
    run_columns('{400, 0});
    // default map back, facing up
    load_config(26'd6553600, 26'd6553600, 24'hC00000, {MAP_HIGH_RST, MAP_LOW_RST});
    run_columns('{0, 400, 799});

    sent = 0;
    while (sent < RANDOM_RAYS) begin
      quiet_mode = ($urandom_range(0, 3) == 0);
      load_config(random_player(), random_player(), ANGLE_W'($urandom()), random_map());
      n = $urandom_range(10, 40);
      repeat (n) column_q.push_back(random_column());
      sent += n;
      wait_idle();
    end

    repeat (MAX_STEPS + SETTLE) @(posedge clk_i);
    if (mismatches == 0) $display("grid_ray_marcher test passed");
    else $display("grid_ray_marcher test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #(40_000_000);
    $display("grid_ray_marcher test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/grm_pkg.sv
rtl/core/grm_sine_rom.sv
rtl/core/grm_march_unit.sv
rtl/core/grid_ray_marcher.sv
sim/grid_ray_marcher_tb.sv
